### design/mslc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslc_pkg
// Shared types and codes for the multibyte sequence length checker: encoding
// group codes, status codes and the result record.
// ----------------------------------------------------------------------------
package mslc_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 3;
    localparam int unsigned GroupW = 4;
    localparam int unsigned StatW  = 2;

    typedef enum logic [GroupW-1:0] {
        GRP_SINGLE   = 4'd0,
        GRP_BIG5     = 4'd1,
        GRP_EUC_CN   = 4'd2,
        GRP_EUC_JP   = 4'd3,
        GRP_EUC_JIS  = 4'd4,
        GRP_EUC_KR   = 4'd5,
        GRP_EUC_TW   = 4'd6,
        GRP_GB18030  = 4'd7,
        GRP_GBK      = 4'd8,
        GRP_JOHAB    = 4'd9,
        GRP_MULE     = 4'd10,
        GRP_SJIS     = 4'd11,
        GRP_SJIS2004 = 4'd12,
        GRP_UHC      = 4'd13,
        GRP_UTF8     = 4'd14
    } group_e_t;

    typedef enum logic [StatW-1:0] {
        STAT_VALID   = 2'd0,
        STAT_END     = 2'd1,
        STAT_INVALID = 2'd2
    } status_e_t;

    // per-encoding verdict: err set means len holds the error span
    typedef struct packed {
        logic              err;
        logic [CountW-1:0] len;
    } verdict_t;

    typedef struct packed {
        status_e_t         status;
        logic [CountW-1:0] seq_len;
        logic [CountW-1:0] error_span;
    } result_t;

endpackage

### design/mslc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslc_check
// Combinational byte range checks for one window under the selected
// encoding group.
// ----------------------------------------------------------------------------
module mslc_check (
    input  mslc_pkg::group_e_t          group,
    input  logic [mslc_pkg::ByteW-1:0]  byte0,
    input  logic [mslc_pkg::ByteW-1:0]  byte1,
    input  logic [mslc_pkg::ByteW-1:0]  byte2,
    input  logic [mslc_pkg::ByteW-1:0]  byte3,
    input  logic [mslc_pkg::CountW-1:0] bytes_left,
    output mslc_pkg::result_t           result
);
    import mslc_pkg::*;

    logic [CountW-1:0] n;
    verdict_t          v;

    function automatic logic rng(input logic [7:0] x, input logic [7:0] lo,
                                 input logic [7:0] hi);
        rng = (x >= lo) && (x <= hi);
    endfunction

    function automatic verdict_t ok(input logic [2:0] len);
        ok = '{err: 1'b0, len: len};
    endfunction

    function automatic verdict_t bad(input logic [2:0] span);
        bad = '{err: 1'b1, len: span};
    endfunction

    function automatic verdict_t chk_big5(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [2:0] cnt);
        if (b0 < 8'h80) chk_big5 = ok(3'd1);
        else if (!rng(b0, 8'h81, 8'hfe) || cnt < 3'd2) chk_big5 = bad(3'd1);
        else if (rng(b1, 8'h40, 8'h7e) || rng(b1, 8'ha1, 8'hfe)) chk_big5 = ok(3'd2);
        else chk_big5 = bad(3'd2);
    endfunction

    function automatic verdict_t chk_euc2(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [2:0] cnt, input logic [7:0] lead_hi,
                                          input logic [2:0] bad_span);
        if (b0 < 8'h80) chk_euc2 = ok(3'd1);
        else if (!rng(b0, 8'ha1, lead_hi) || cnt < 3'd2) chk_euc2 = bad(3'd1);
        else if (!rng(b1, 8'ha1, 8'hfe)) chk_euc2 = bad(bad_span);
        else chk_euc2 = ok(3'd2);
    endfunction

    function automatic verdict_t chk_eucjp(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [2:0] cnt);
        if (b0 < 8'h80) chk_eucjp = ok(3'd1);
        else if (cnt < 3'd2) chk_eucjp = bad(3'd1);
        else if (b0 == 8'h8e || rng(b0, 8'ha1, 8'hfe))
            chk_eucjp = rng(b1, 8'ha1, 8'hfe) ? ok(3'd2) : bad(3'd2);
        else if (b0 == 8'h8f && cnt >= 3'd3)
            chk_eucjp = (rng(b1, 8'ha1, 8'hfe) && rng(b2, 8'ha1, 8'hfe))
                ? ok(3'd3) : bad(3'd3);
        else chk_eucjp = bad(3'd1);
    endfunction

    function automatic verdict_t chk_euctw(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] cnt);
        if (b0 < 8'h80) chk_euctw = ok(3'd1);
        else if (cnt < 3'd2) chk_euctw = bad(3'd1);
        else if (rng(b0, 8'ha1, 8'hfe))
            chk_euctw = rng(b1, 8'ha1, 8'hfe) ? ok(3'd2) : bad(3'd2);
        else if (b0 != 8'h8e || cnt < 3'd4) chk_euctw = bad(3'd1);
        else if (rng(b1, 8'ha1, 8'hb0) && rng(b2, 8'ha1, 8'hfe) && rng(b3, 8'ha1, 8'hfe))
            chk_euctw = ok(3'd4);
        else chk_euctw = bad(3'd4);
    endfunction

    function automatic verdict_t chk_gb18030(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] cnt);
        if (b0 < 8'h80) chk_gb18030 = ok(3'd1);
        else if (cnt < 3'd2) chk_gb18030 = bad(cnt);
        else if (rng(b1, 8'h40, 8'hfe))
            chk_gb18030 = (b1 == 8'h7f) ? bad(3'd2) : ok(3'd2);
        else if (cnt < 3'd4) chk_gb18030 = bad(cnt);
        else if (rng(b1, 8'h30, 8'h39) && rng(b2, 8'h81, 8'hfe) && rng(b3, 8'h30, 8'h39))
            chk_gb18030 = ok(3'd4);
        else chk_gb18030 = bad(3'd4);
    endfunction

    function automatic verdict_t chk_gbk(input logic [7:0] f, input logic [7:0] s,
                                         input logic [2:0] cnt);
        logic hi;
        logic lo;
        hi = rng(s, 8'ha1, 8'hfe);
        lo = rng(s, 8'h40, 8'ha0) && s != 8'h7f;
        if (f < 8'h80) chk_gbk = ok(3'd1);
        else if (cnt < 3'd2) chk_gbk = bad(3'd1);
        else if ((rng(f, 8'ha1, 8'ha9) && hi) || (rng(f, 8'hb0, 8'hf7) && hi) ||
                 (rng(f, 8'h81, 8'ha0) && rng(s, 8'h40, 8'hfe) && s != 8'h7f) ||
                 (rng(f, 8'haa, 8'hfe) && lo) || (rng(f, 8'ha8, 8'ha9) && lo) ||
                 (rng(f, 8'haa, 8'haf) && hi) || (rng(f, 8'hf8, 8'hfe) && hi) ||
                 (rng(f, 8'ha1, 8'ha7) && lo))
            chk_gbk = ok(3'd2);
        else chk_gbk = bad(3'd2);
    endfunction

    function automatic verdict_t chk_johab(input logic [7:0] f, input logic [7:0] s,
                                           input logic [2:0] cnt);
        if (f < 8'h80) chk_johab = ok(3'd1);
        else if (cnt < 3'd2) chk_johab = bad(3'd1);
        else if ((rng(f, 8'h84, 8'hd3) && (rng(s, 8'h41, 8'h7e) || rng(s, 8'h81, 8'hfe))) ||
                 ((rng(f, 8'hd8, 8'hde) || rng(f, 8'he0, 8'hf9)) &&
                  (rng(s, 8'h31, 8'h7e) || rng(s, 8'h91, 8'hfe))))
            chk_johab = ok(3'd2);
        else chk_johab = bad(3'd2);
    endfunction

    function automatic verdict_t chk_mule(input logic [7:0] f, input logic [7:0] s,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] cnt);
        if (f < 8'h80) chk_mule = ok(3'd1);
        else if (cnt < 3'd2) chk_mule = bad(3'd1);
        else if (rng(f, 8'h81, 8'h8d) && s >= 8'ha0) chk_mule = ok(3'd2);
        else if (cnt < 3'd3) chk_mule = bad(3'd2);
        else if (((f == 8'h9a && rng(s, 8'ha0, 8'hdf)) ||
                  (f == 8'h9b && rng(s, 8'he0, 8'hef)) ||
                  (rng(f, 8'h90, 8'h99) && s >= 8'ha0)) && s >= 8'ha0)
            chk_mule = ok(3'd3);
        else if (cnt < 3'd4) chk_mule = bad(3'd3);
        else if (((f == 8'h9c && rng(s, 8'hf0, 8'hf4)) ||
                  (f == 8'h9d && rng(s, 8'hf5, 8'hfe))) && b2 >= 8'ha0 && b3 >= 8'ha0)
            chk_mule = ok(3'd4);
        else chk_mule = bad(3'd4);
    endfunction

    function automatic verdict_t chk_sjis(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [2:0] cnt);
        if (b0 < 8'h80 || rng(b0, 8'ha1, 8'hdf)) chk_sjis = ok(3'd1);
        else if (!rng(b0, 8'h81, 8'h9f) && !rng(b0, 8'he0, 8'hfc)) chk_sjis = bad(3'd1);
        else if (cnt < 3'd2) chk_sjis = bad(cnt);
        else if (b1 == 8'h7f) chk_sjis = bad(3'd2);
        else chk_sjis = rng(b1, 8'h40, 8'hfc) ? ok(3'd2) : bad(3'd2);
    endfunction

    function automatic verdict_t chk_uhc(input logic [7:0] b0, input logic [7:0] s,
                                         input logic [2:0] cnt);
        if (b0 < 8'h80) chk_uhc = ok(3'd1);
        else if (cnt < 3'd2) chk_uhc = bad(cnt);
        else if (rng(b0, 8'h80, 8'hc6))
            chk_uhc = (rng(s, 8'h41, 8'h5a) || rng(s, 8'h61, 8'h7a) || rng(s, 8'h80, 8'hfe))
                ? ok(3'd2) : bad(3'd2);
        else if (rng(b0, 8'ha1, 8'hfe))
            chk_uhc = rng(s, 8'ha1, 8'hfe) ? ok(3'd2) : bad(3'd2);
        else chk_uhc = bad(3'd1);
    endfunction

    function automatic verdict_t chk_utf8(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] cnt);
        logic c1;
        logic c2;
        logic c3;
        c1 = rng(b1, 8'h80, 8'hbf);
        c2 = rng(b2, 8'h80, 8'hbf);
        c3 = rng(b3, 8'h80, 8'hbf);
        if (b0 < 8'h80) chk_utf8 = ok(3'd1);
        else if (cnt < 3'd2) chk_utf8 = bad(cnt);
        else if (rng(b0, 8'hc0, 8'hdf)) chk_utf8 = c1 ? ok(3'd2) : bad(3'd2);
        else if (cnt < 3'd3) chk_utf8 = bad(cnt);
        else if (rng(b0, 8'he0, 8'hef)) chk_utf8 = (c1 && c2) ? ok(3'd3) : bad(3'd3);
        else if (cnt < 3'd4) chk_utf8 = bad(cnt);
        else if (rng(b0, 8'hf0, 8'hf7)) chk_utf8 = (c1 && c2 && c3) ? ok(3'd4) : bad(3'd4);
        else chk_utf8 = bad(3'd1);
    endfunction

    // remaining count saturates at four
    assign n = (bytes_left > 3'd4) ? 3'd4 : bytes_left;

    always_comb
    begin
        unique case (group)
            GRP_BIG5:                v = chk_big5(byte0, byte1, n);
            GRP_EUC_CN:              v = chk_euc2(byte0, byte1, n, 8'hf7, 3'd2);
            GRP_EUC_JP, GRP_EUC_JIS: v = chk_eucjp(byte0, byte1, byte2, n);
            GRP_EUC_KR:              v = chk_euc2(byte0, byte1, n, 8'hfe, 3'd1);
            GRP_EUC_TW:              v = chk_euctw(byte0, byte1, byte2, byte3, n);
            GRP_GB18030:             v = chk_gb18030(byte0, byte1, byte2, byte3, n);
            GRP_GBK:                 v = chk_gbk(byte0, byte1, n);
            GRP_JOHAB:               v = chk_johab(byte0, byte1, n);
            GRP_MULE:                v = chk_mule(byte0, byte1, byte2, byte3, n);
            GRP_SJIS, GRP_SJIS2004:  v = chk_sjis(byte0, byte1, n);
            GRP_UHC:                 v = chk_uhc(byte0, byte1, n);
            GRP_UTF8:                v = chk_utf8(byte0, byte1, byte2, byte3, n);
            default:                 v = ok(3'd1);
        endcase
    end

    always_comb
    begin
        if (n == '0)
            result = '{status: STAT_END, seq_len: '0, error_span: '0};
        else if (v.err)
            result = '{status: STAT_INVALID, seq_len: '0, error_span: v.len};
        else
            result = '{status: STAT_VALID, seq_len: v.len, error_span: '0};
    end

endmodule

### design/multibyte_sequence_length_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibyte_sequence_length_checker_core
// Checks a window of up to four bytes at a character boundary against the
// byte rules of one of fifteen encoding groups and reports end of data,
// a valid sequence length, or an invalid sequence span.
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge with start high; busy is never
// raised, so one window can follow another in every cycle. Each transaction
// gives exactly one result, on status / seq_len / error_span while done is
// high for one cycle. The window goes into the input register at the edge
// that takes the transaction, and the range-check logic loads the result
// register at the next edge, so done is high in the cycle after that next
// edge. The receiver cannot stall and must take the result in that cycle.
// The encoding group is written through cfg_we / cfg_wdata and must only
// change while no transaction is in flight.
// ----------------------------------------------------------------------------
module multibyte_sequence_length_checker_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mslc_pkg::GroupW-1:0]   cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [mslc_pkg::ByteW-1:0]    byte0,
    input  logic [mslc_pkg::ByteW-1:0]    byte1,
    input  logic [mslc_pkg::ByteW-1:0]    byte2,
    input  logic [mslc_pkg::ByteW-1:0]    byte3,
    input  logic [mslc_pkg::CountW-1:0]   bytes_left,
    output logic                          done,
    output logic [mslc_pkg::StatW-1:0]    status,
    output logic [mslc_pkg::CountW-1:0]   seq_len,
    output logic [mslc_pkg::CountW-1:0]   error_span
);
    import mslc_pkg::*;

    // configuration
    group_e_t          group_reg;

    // input stage
    logic              stage_valid_reg;
    logic [ByteW-1:0]  byte0_reg;
    logic [ByteW-1:0]  byte1_reg;
    logic [ByteW-1:0]  byte2_reg;
    logic [ByteW-1:0]  byte3_reg;
    logic [CountW-1:0] bytes_left_reg;

    // result stage
    logic              done_reg;
    result_t           result_next;
    result_t           result_reg;

    logic              accept;

    // the pipeline never holds off a new transaction
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // encoding group register, codes 0..15 all map onto the enum width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            group_reg <= GRP_SINGLE;
        else if (cfg_we)
            group_reg <= group_e_t'(cfg_wdata);
    end

    // input register: window and remaining count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte0_reg      <= byte0;
            byte1_reg      <= byte1;
            byte2_reg      <= byte2;
            byte3_reg      <= byte3;
            bytes_left_reg <= bytes_left;
        end
    end

    // range checks for the selected group
    mslc_check u_check (
        .group      (group_reg),
        .byte0      (byte0_reg),
        .byte1      (byte1_reg),
        .byte2      (byte2_reg),
        .byte3      (byte3_reg),
        .bytes_left (bytes_left_reg),
        .result     (result_next)
    );

    // result register, strobe lasts one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
            result_reg <= result_next;
    end

    assign done       = done_reg;
    assign status     = result_reg.status;
    assign seq_len    = result_reg.seq_len;
    assign error_span = result_reg.error_span;

`ifndef SYNTHESIS
    // every strobe comes from a window held in the input stage
    a_done_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(stage_valid_reg))
        else $error("result strobe without a staged transaction");

    // a valid result carries a length and no span
    a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_VALID) |-> (seq_len != '0 && error_span == '0))
        else $error("valid result with bad length or span");

    // an invalid result carries a span of one to four and no length
    a_invalid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_INVALID) |->
            (seq_len == '0 && error_span != '0 && error_span <= 3'd4))
        else $error("invalid result with bad length or span");

    // end of data exactly when the staged count was zero
    a_end_of_data: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == STAT_END) == ($past(bytes_left_reg) == '0)))
        else $error("end of data status does not match remaining count");
`endif

endmodule
